FILE: hdl/url_dec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// url_dec_pkg
// shared types, character codes and hex helpers for the url decoder
// ----------------------------------------------------------------------------
package url_dec_pkg;

    // escape parser phase
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_PCT  = 3'd1,
        PH_HEX1 = 3'd2,
        PH_U0   = 3'd3,
        PH_U1   = 3'd4,
        PH_U2   = 3'd5,
        PH_U3   = 3'd6
    } phase_t;

    // string status reported on the last decoded byte
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_ESCAPE = 2'd1,
        ST_BAD_PATH   = 2'd2
    } status_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  held;
        logic [15:0] accum;
        logic        group_inv;
        logic        bad_esc;
        logic        bad_path;
    } esc_state_t;

    // decoded bytes caused by one request, oldest in bytes[0]
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] bytes;
        logic            final_flag;
        status_t         status;
    } bundle_t;

    localparam int unsigned MAX_BYTES = 3;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_U_LO  = 8'h75;
    localparam logic [7:0] CH_U_UP  = 8'h55;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;

    localparam esc_state_t ESC_STATE_RESET = '{
        phase:     PH_IDLE,
        held:      8'h00,
        accum:     16'h0000,
        group_inv: 1'b0,
        bad_esc:   1'b0,
        bad_path:  1'b0
    };

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_A_LO && c <= CH_F_LO) ||
               (c >= CH_A_UP && c <= CH_F_UP);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        begin
            if (c >= CH_A_UP)
                t = ((c & 8'hDF) - CH_A_UP) + 8'd10;
            else
                t = c - CH_0;
            return t[3:0];
        end
    endfunction

endpackage : url_dec_pkg
`default_nettype wire

FILE: hdl/url_dec_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// url_dec_in_if
// encoded byte channel: valid/ready plus one raw byte and end-of-string mark
// ----------------------------------------------------------------------------
interface url_dec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_string;

    modport source (output valid, output char_in, output end_of_string, input ready);
    modport sink   (input valid, input char_in, input end_of_string, output ready);
endinterface : url_dec_in_if
`default_nettype wire

FILE: hdl/url_dec_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// url_dec_out_if
// decoded byte channel: valid/ready plus byte, last flag and string status
// ----------------------------------------------------------------------------
interface url_dec_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       final_out;
    logic [1:0] decode_status;

    modport source (output valid, output char_out, output final_out,
                    output decode_status, input ready);
    modport sink   (input valid, input char_out, input final_out,
                    input decode_status, output ready);
endinterface : url_dec_out_if
`default_nettype wire

FILE: hdl/url_dec_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// url_dec_core
// one-byte step of the escape parser: next state and up to three output bytes
// ----------------------------------------------------------------------------
module url_dec_core
    import url_dec_pkg::*;
(
    input  esc_state_t state,
    input  logic [7:0] char_in,
    input  logic       end_of_string,
    output esc_state_t state_next,
    output bundle_t    bundle
);

    function automatic bundle_t push_byte(input bundle_t b, input logic [7:0] v);
        bundle_t r;
        begin
            r = b;
            if (r.count != 2'(MAX_BYTES))
            begin
                r.bytes[r.count] = v;
                r.count          = r.count + 2'd1;
            end
            return r;
        end
    endfunction

    // code point to 1..3 utf-8 bytes
    function automatic bundle_t emit_code(input bundle_t b, input logic [15:0] cp);
        bundle_t r;
        begin
            r = b;
            if (cp < 16'h0080)
                r = push_byte(r, cp[7:0]);
            else if (cp < 16'h0800)
            begin
                r = push_byte(r, 8'hC0 | {3'b000, cp[10:6]});
                r = push_byte(r, 8'h80 | {2'b00, cp[5:0]});
            end
            else
            begin
                r = push_byte(r, 8'hE0 | {4'h0, cp[15:12]});
                r = push_byte(r, 8'h80 | {2'b00, cp[11:6]});
                r = push_byte(r, 8'h80 | {2'b00, cp[5:0]});
            end
            return r;
        end
    endfunction

    logic [7:0]  c;
    logic        c_hex;
    logic [3:0]  c_val;
    logic        do_plain;
    logic [7:0]  pair_val;
    logic [15:0] acc_new;
    logic        inv_new;
    esc_state_t  s;
    bundle_t     r;

    assign c        = (char_in == CH_PLUS) ? CH_SPACE : char_in;
    assign c_hex    = is_hex(c);
    assign c_val    = hex_val(c);
    assign pair_val = {hex_val(state.held), c_val};
    assign acc_new  = c_hex ? {state.accum[11:0], c_val} : state.accum;
    assign inv_new  = state.group_inv | ~c_hex;

    always_comb
    begin
        s        = state;
        r        = '0;
        do_plain = 1'b0;
        unique case (state.phase) inside
            PH_PCT:
            begin
                if (c == CH_U_LO || c == CH_U_UP)
                begin
                    if (end_of_string)
                        r = push_byte(r, CH_NUL);
                    else
                    begin
                        s.phase     = PH_U0;
                        s.accum     = 16'h0000;
                        s.group_inv = 1'b0;
                    end
                end
                else if (c_hex)
                begin
                    if (end_of_string)
                    begin
                        r         = push_byte(r, CH_PCT);
                        r         = push_byte(r, c);
                        s.bad_esc = 1'b1;
                        s.phase   = PH_IDLE;
                    end
                    else
                    begin
                        s.held  = c;
                        s.phase = PH_HEX1;
                    end
                end
                else
                begin
                    r         = push_byte(r, CH_PCT);
                    s.bad_esc = 1'b1;
                    s.phase   = PH_IDLE;
                    do_plain  = 1'b1;
                end
            end
            PH_HEX1:
            begin
                s.phase = PH_IDLE;
                if (c_hex)
                begin
                    r = push_byte(r, pair_val);
                    if (pair_val == CH_SLASH || pair_val == CH_NUL)
                        s.bad_path = 1'b1;
                end
                else
                begin
                    r         = push_byte(r, CH_PCT);
                    r         = push_byte(r, state.held);
                    s.bad_esc = 1'b1;
                    do_plain  = 1'b1;
                end
            end
            PH_U0, PH_U1, PH_U2, PH_U3:
            begin
                s.accum     = acc_new;
                s.group_inv = inv_new;
                if (state.phase == PH_U3)
                begin
                    r       = emit_code(r, inv_new ? 16'h0000 : acc_new);
                    s.phase = PH_IDLE;
                end
                else if (end_of_string)
                begin
                    r       = push_byte(r, CH_NUL);
                    s.phase = PH_IDLE;
                end
                else
                    s.phase = phase_t'(state.phase + 3'd1);
            end
            default:
            begin
                s.phase  = PH_IDLE;
                do_plain = 1'b1;
            end
        endcase

        // current byte handled as ordinary input
        if (do_plain)
        begin
            if (c == CH_PCT)
            begin
                if (end_of_string)
                begin
                    r         = push_byte(r, CH_PCT);
                    s.bad_esc = 1'b1;
                end
                else
                    s.phase = PH_PCT;
            end
            else
                r = push_byte(r, c);
        end

        if (end_of_string)
        begin
            if (r.count != 2'd0)
            begin
                r.final_flag = 1'b1;
                r.status     = s.bad_esc ? ST_BAD_ESCAPE :
                               (s.bad_path ? ST_BAD_PATH : ST_OK);
            end
            s = ESC_STATE_RESET;
        end

        state_next = s;
        bundle     = r;
    end

endmodule : url_dec_core
`default_nettype wire

FILE: hdl/url_dec_rqueue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// url_dec_rqueue
// two-entry queue of byte bundles, drained one byte per request
// ----------------------------------------------------------------------------
module url_dec_rqueue
    import url_dec_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bundle_t       push_data,
    output logic          full,
    url_dec_out_if.source dec
);

    bundle_t    slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic [1:0] byte_idx_reg;
    bundle_t    head;
    logic       take;
    logic       last;
    logic       pop;

    assign head = slot_reg[rd_ptr_reg];
    assign full = (cnt_reg == 2'd2);
    assign take = dec.valid & dec.ready;
    assign last = (byte_idx_reg == head.count - 2'd1);
    assign pop  = take & last;

    assign dec.valid         = (cnt_reg != 2'd0);
    assign dec.char_out      = head.bytes[byte_idx_reg];
    assign dec.final_out     = head.final_flag & last;
    assign dec.decode_status = (head.final_flag & last) ? head.status : ST_OK;

    always_comb
    begin
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            cnt_reg      <= 2'd0;
            byte_idx_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (take)
                byte_idx_reg <= last ? 2'd0 : byte_idx_reg + 2'd1;
        end
    end

endmodule : url_dec_rqueue
`default_nettype wire

FILE: hdl/url_percent_unicode_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// url_percent_unicode_decoder
// form-urlencoded decoder: '+', %HH and %uXXXX (to utf-8), one raw byte per
// request, with bad-escape / slash-or-null status on the last decoded byte
// ----------------------------------------------------------------------------
//
//  channel  role    payload                                  per request
//  -------  ------  ---------------------------------------  -----------------
//  enc      sink    char_in[7:0], end_of_string              one raw byte
//  dec      source  char_out[7:0], final_out, decode_status  one decoded byte
//
//  - a raw byte is taken every cycle while the result queue has a free slot;
//    the parser state updates in the same edge, so there is no bubble
//  - a request makes 0..3 decoded bytes; the result side drains one byte per
//    cycle while dec.ready is high
//  - the two-entry result queue sets enc.ready: it drops only when both slots
//    hold undelivered bytes, so a stalled dec side backs up after two
//    requests that produce bytes (requests that produce none take no slot)
//  - rst_n clears parser state and the queue pointers asynchronously
//
module url_percent_unicode_decoder
    import url_dec_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    url_dec_in_if.sink    enc,
    url_dec_out_if.source dec
);

    esc_state_t state_reg;
    esc_state_t state_next;
    bundle_t    step_bundle;
    logic       q_full;
    logic       accept;

    // request accepted on this edge
    assign enc.ready = ~q_full;
    assign accept    = enc.valid & enc.ready;

    // escape parser step, purely combinational from the held state
    url_dec_core u_core (
        .state         (state_reg),
        .char_in       (enc.char_in),
        .end_of_string (enc.end_of_string),
        .state_next    (state_next),
        .bundle        (step_bundle)
    );

    // requests that decode to nothing (pending escape bytes) skip the queue
    url_dec_rqueue u_rqueue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && (step_bundle.count != 2'd0)),
        .push_data (step_bundle),
        .full      (q_full),
        .dec       (dec)
    );

    // parser state only moves on an accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ESC_STATE_RESET;
        else if (accept)
            state_reg <= state_next;
    end

    // end of string always returns the parser to idle with clean flags
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && enc.end_of_string |=>
            state_reg.phase == PH_IDLE && !state_reg.bad_esc && !state_reg.bad_path)
        else $error("parser state not cleared after end of string");

    // an end-of-string request always yields at least one decoded byte
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && enc.end_of_string |-> step_bundle.count != 2'd0)
        else $error("end of string produced no decoded byte");

    // status is only reported on the last byte of a string
    assert property (@(posedge clk) disable iff (!rst_n)
        dec.valid && !dec.final_out |-> dec.decode_status == ST_OK)
        else $error("status on a non-final byte");

    // back-pressure only while decoded bytes are waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !enc.ready |-> dec.valid)
        else $error("input stalled with empty result queue");

endmodule : url_percent_unicode_decoder
`default_nettype wire
